// ===== hdl/fsts_pkg.sv =====
// Shared types and constants for the fill-and-set table with running sum.
// Used by fill_and_set_table_with_sum_unit; depends on nothing else.
`timescale 1ns / 1ps

package fsts_pkg;

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 10;
	localparam int IN_VAL_W  = 32;
	localparam int COUNT_W   = 11;
	localparam int TOTAL_W   = 43;
	localparam int OUT_TOT_W = 42;
	localparam int EPOCH_W   = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_STALE = 8'd0;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_SET  = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [INDEX_W-1:0]  index;
		logic [IN_VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [OUT_TOT_W-1:0] total;
		logic                 error;
	} rsp_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

// ===== hdl/fill_and_set_table_with_sum_unit.sv =====
// Value table with a running total of its active entries (top level).
// Depends on fsts_pkg for the transaction types, opcodes and widths.
`timescale 1ns / 1ps

// A request is read from the value and tag memories at acceptance and finished
// in stage 1, so one transaction is taken per clock when the response side keeps
// up and no tag sweep runs; its response is then held in the output register. The
// rate is set by the single read-modify-write of the value memory, with a bypass
// for back-to-back requests to the same entry. Fresh marks are epoch tags held
// next to each entry and a fill just advances the epoch. After reset the tag
// memory is swept back to stale, one entry per cycle, across all DEPTH entries.
// Every 255th fill runs out the epoch and starts the same sweep; requests are held
// while that fill is in stage 1 and during the sweep (config writes still land).
module fill_and_set_table_with_sum_unit #(
	parameter int DEPTH       = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [fsts_pkg::COUNT_W-1:0]   cfg_wr_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  fsts_pkg::req_t                 req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fsts_pkg::rsp_t                 rsp_data
);

	localparam int VW   = (VALUE_WIDTH < fsts_pkg::IN_VAL_W) ? VALUE_WIDTH : fsts_pkg::IN_VAL_W;
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > fsts_pkg::COUNT_W) ? CW : fsts_pkg::COUNT_W;
	localparam int PW   = VW + CMPW;
	localparam int TW   = fsts_pkg::TOTAL_W;
	localparam int EW   = fsts_pkg::EPOCH_W;

	localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(DEPTH);
	localparam logic [AW-1:0]   CLR_LAST  = AW'(DEPTH - 1);

	// storage
	logic [VW-1:0] val_mem [DEPTH];
	logic [EW-1:0] tag_mem [DEPTH];

	// control registers
	fsts_pkg::state_t            state_q, state_d;
	logic [AW-1:0]               clr_addr_q;
	logic [fsts_pkg::COUNT_W-1:0] entry_count_q;
	logic [EW-1:0]               epoch_q;
	logic                        fill_seen_q;
	logic [VW-1:0]               fill_value_q;
	logic [TW-1:0]               total_q;

	// stage 1
	logic                        s1_valid_s1;
	fsts_pkg::req_t              req_s1;
	logic [VW-1:0]               mem_val_s1;
	logic [EW-1:0]               mem_tag_s1;
	logic                        fwd_hit_s1;
	logic [VW-1:0]               fwd_val_s1;
	logic [EW-1:0]               fwd_tag_s1;

	// output register
	logic                        rsp_valid_q;
	fsts_pkg::rsp_t              rsp_data_q;

	// combinational
	logic                        req_acc;
	logic                        out_ready;
	logic                        s1_go;
	logic                        wrap_pending;
	logic                        clr_we;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic                        mem_we;
	logic [CMPW-1:0]             count_ext;
	logic [CMPW-1:0]             active;
	logic [CMPW-1:0]             idx_ext;
	logic                        bad_idx;
	logic [VW-1:0]               val_s1;
	logic [VW-1:0]               rd_val;
	logic [EW-1:0]               rd_tag;
	logic [VW-1:0]               removed;
	logic [PW-1:0]               product;
	logic [TW-1:0]               total_d;
	logic                        has_rsp;
	logic                        rsp_err;
	logic                        is_fill;

	assign count_ext = CMPW'(entry_count_q);
	assign active    = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;

	assign out_ready    = !rsp_valid_q || !rsp_stall;
	assign s1_go        = s1_valid_s1 && out_ready;
	assign is_fill      = (req_s1.operation == fsts_pkg::OP_FILL);
	// a fill that exhausts the epoch is followed by a tag sweep: hold new requests
	assign wrap_pending = s1_valid_s1 && is_fill && (epoch_q == fsts_pkg::EPOCH_LAST);

	// sweep state machine and request stall
	always_comb begin
		state_d   = state_q;
		clr_we    = 1'b0;
		req_stall = 1'b1;
		case (state_q)
			fsts_pkg::ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_addr_q == CLR_LAST) begin
					state_d = fsts_pkg::ST_RUN;
				end
			end
			fsts_pkg::ST_RUN: begin
				req_stall = (s1_valid_s1 && !out_ready) || wrap_pending;
				if (s1_go && wrap_pending) begin
					state_d = fsts_pkg::ST_CLEAR;
				end
			end
			default: begin
				state_d = fsts_pkg::ST_CLEAR;
			end
		endcase
	end

	assign req_acc = req_valid && !req_stall;
	assign rd_addr = AW'(req_data.index);

	// stage 1 datapath
	always_comb begin
		idx_ext = CMPW'(req_s1.index);
		val_s1  = VW'(req_s1.value);
		bad_idx = ((req_s1.operation == fsts_pkg::OP_LOAD) ||
		           (req_s1.operation == fsts_pkg::OP_SET)) && (idx_ext >= active);
		rd_val  = fwd_hit_s1 ? fwd_val_s1 : mem_val_s1;
		rd_tag  = fwd_hit_s1 ? fwd_tag_s1 : mem_tag_s1;
		removed = ((rd_tag == epoch_q) || !fill_seen_q) ? rd_val : fill_value_q;
		product = PW'(val_s1) * PW'(active);
		total_d = total_q;
		has_rsp = 1'b0;
		rsp_err = 1'b0;
		mem_we  = 1'b0;
		if (bad_idx) begin
			has_rsp = 1'b1;
			rsp_err = 1'b1;
		end else begin
			case (req_s1.operation)
				fsts_pkg::OP_LOAD: begin
					total_d = total_q + TW'(val_s1);
					mem_we  = s1_go;
				end
				fsts_pkg::OP_SET: begin
					total_d = total_q - TW'(removed) + TW'(val_s1);
					mem_we  = s1_go;
					has_rsp = 1'b1;
				end
				fsts_pkg::OP_FILL: begin
					total_d = TW'(product);
					has_rsp = 1'b1;
				end
				default: begin
					total_d = total_q;
				end
			endcase
		end
	end

	assign wr_addr = clr_we ? clr_addr_q : AW'(req_s1.index);

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_mem[wr_addr] <= val_s1;
		end
		if (req_acc) begin
			mem_val_s1 <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we || clr_we) begin
			tag_mem[wr_addr] <= clr_we ? fsts_pkg::EPOCH_STALE : epoch_q;
		end
		if (req_acc) begin
			mem_tag_s1 <= tag_mem[rd_addr];
		end
	end

	// payload of stage 1 and the bypass of a write landing on the entry being read
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1     <= req_data;
			fwd_val_s1 <= val_s1;
			fwd_tag_s1 <= epoch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fsts_pkg::ST_CLEAR;
			clr_addr_q    <= '0;
			entry_count_q <= fsts_pkg::COUNT_RESET;
			epoch_q       <= fsts_pkg::EPOCH_FIRST;
			fill_seen_q   <= 1'b0;
			fill_value_q  <= '0;
			total_q       <= '0;
			s1_valid_s1   <= 1'b0;
			fwd_hit_s1    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_addr_q <= (clr_addr_q == CLR_LAST) ? '0 : clr_addr_q + AW'(1);
			end
			if (cfg_wr_en) begin
				entry_count_q <= cfg_wr_data;
			end
			if (req_acc) begin
				s1_valid_s1 <= 1'b1;
				fwd_hit_s1  <= mem_we && (wr_addr == rd_addr);
			end else if (s1_go) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				total_q <= total_d;
				if (is_fill) begin
					fill_seen_q  <= 1'b1;
					fill_value_q <= val_s1;
					epoch_q      <= wrap_pending ? fsts_pkg::EPOCH_FIRST : epoch_q + EW'(1);
				end
			end
			if (s1_go && has_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_rsp) begin
			rsp_data_q.total <= total_d[fsts_pkg::OUT_TOT_W-1:0];
			rsp_data_q.error <= rsp_err;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for fill_and_set_table_with_sum_unit: a directed opening, then
// random load/set/fill traffic under several entry counts, checked by a scoreboard.
// Depends on fsts_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH   = 1024;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int OPW           = fsts_pkg::OP_W;
	localparam int IDX_W         = fsts_pkg::INDEX_W;
	localparam int VAL_W         = fsts_pkg::IN_VAL_W;
	localparam int CNT_W         = fsts_pkg::COUNT_W;
	localparam int TOT_W         = fsts_pkg::TOTAL_W;
	localparam int OTOT_W        = fsts_pkg::OUT_TOT_W;
	localparam logic [OPW-1:0]   OP_NONE   = 2'd3;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'h7FF;

	// Tracks the table, fresh marks and running sum; holds expected responses.
	class table_scoreboard;
		logic [VAL_W-1:0]  entry_val [TABLE_DEPTH];
		bit                fresh [TABLE_DEPTH];
		bit                fill_seen;
		logic [VAL_W-1:0]  fill_val;
		logic [TOT_W-1:0]  sum;
		logic [CNT_W-1:0]  count_reg;
		fsts_pkg::rsp_t    exp_totals[$];
		int                errors;

		function new();
			fill_seen = 0;
			fill_val  = '0;
			sum       = '0;
			count_reg = fsts_pkg::COUNT_RESET;
			errors    = 0;
			foreach (fresh[i]) fresh[i] = 0;
			foreach (entry_val[i]) entry_val[i] = 'x;
		endfunction

		function int unsigned active();
			return (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
		endfunction

		function void push_total(bit err);
			fsts_pkg::rsp_t e;
			e.total = sum[OTOT_W-1:0];
			e.error = err;
			exp_totals = {exp_totals, e};
		endfunction

		function void note_request(fsts_pkg::req_t r);
			int unsigned      n;
			logic [VAL_W-1:0] removed;
			n = active();
			if (r.operation == fsts_pkg::OP_FILL) begin
				fill_seen = 1;
				fill_val  = r.value;
				foreach (fresh[i]) fresh[i] = 0;
				sum = TOT_W'(r.value) * TOT_W'(n);
				push_total(0);
			end else if (r.operation == fsts_pkg::OP_LOAD ||
					r.operation == fsts_pkg::OP_SET) begin
				if (r.index >= n) begin
					push_total(1);
				end else if (r.operation == fsts_pkg::OP_LOAD) begin
					entry_val[r.index] = r.value;
					fresh[r.index]     = 1;
					sum = sum + TOT_W'(r.value);
				end else begin
					// entries untouched since the last fill read back the fill value
					removed = (fresh[r.index] || !fill_seen) ? entry_val[r.index] : fill_val;
					sum = sum - TOT_W'(removed) + TOT_W'(r.value);
					entry_val[r.index] = r.value;
					fresh[r.index]     = 1;
					push_total(0);
				end
			end
		endfunction

		function void check_total(fsts_pkg::rsp_t got);
			fsts_pkg::rsp_t e;
			if (exp_totals.size() == 0) begin
				$display("%0t: unexpected response: expected none, got total %h error %b",
					$time, got.total, got.error);
				errors++;
				return;
			end
			e = exp_totals.pop_front();
			if (got.total !== e.total) begin
				$display("%0t: total mismatch: expected %h, got %h", $time, e.total, got.total);
				errors++;
			end
			if (got.error !== e.error) begin
				$display("%0t: error flag mismatch: expected %b, got %b", $time, e.error,
					got.error);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	logic             req_valid;
	logic             req_stall;
	fsts_pkg::req_t   req_data;
	logic             rsp_valid;
	logic             rsp_stall;
	fsts_pkg::rsp_t   rsp_data;

	table_scoreboard sb;
	bit              idle_on;
	bit              quiet;
	int unsigned     stall_left;
	int unsigned     cycles;

	fill_and_set_table_with_sum_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// response-side backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_total(rsp_data);
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic fsts_pkg::req_t pick_request(int unsigned fill_pct);
		fsts_pkg::req_t r;
		int unsigned    n;
		int unsigned    roll;
		bit             bad;
		n    = sb.active();
		roll = $urandom_range(0, 99);
		bad  = 0;
		r.value = pick_value();
		r.index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
		if (roll < fill_pct) begin
			r.operation = fsts_pkg::OP_FILL;
		end else if (roll < fill_pct + 5) begin
			r.operation = OP_NONE;
		end else begin
			r.operation = ($urandom_range(0, 4) < 2) ? fsts_pkg::OP_LOAD : fsts_pkg::OP_SET;
			bad = (roll < fill_pct + 12);
		end
		if (r.operation inside {fsts_pkg::OP_LOAD, fsts_pkg::OP_SET}) begin
			if (bad && n < TABLE_DEPTH)
				r.index = IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
			else if (!bad && n > 0)
				r.index = IDX_W'($urandom_range(0, n - 1));
		end
		// never read back an entry that was never loaded
		if (r.operation == fsts_pkg::OP_SET && r.index < n && !sb.fill_seen &&
				$isunknown(sb.entry_val[r.index]))
			r.operation = fsts_pkg::OP_LOAD;
		return r;
	endfunction

	task automatic send(fsts_pkg::req_t r);
		int unsigned gap;
		if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic issue(logic [OPW-1:0] op, int unsigned idx, logic [VAL_W-1:0] val);
		fsts_pkg::req_t r;
		r.operation = op;
		r.index     = IDX_W'(idx);
		r.value     = val;
		send(r);
	endtask

	// loads give no response, so keep waiting after the last response for them to land
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.exp_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_entry_count(logic [CNT_W-1:0] cnt);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cnt;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		sb.count_reg = cnt;
	endtask

	initial begin
		int unsigned      n_random;
		int unsigned      phase;
		int unsigned      len;
		int unsigned      fill_pct;
		int unsigned      i;
		logic [CNT_W-1:0] cnt;
		fsts_pkg::req_t   r;

		sb         = new();
		idle_on    = 1;
		quiet      = 0;
		stall_left = 0;
		cycles     = 0;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		req_valid   <= 1'b0;
		req_data    <= '0;
		rsp_stall   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset count, value extremes, fresh vs. stale after fill
		issue(fsts_pkg::OP_LOAD, 0, '0);
		issue(fsts_pkg::OP_LOAD, 1023, '1);
		issue(fsts_pkg::OP_LOAD, 1, 32'h5555_5555);
		issue(fsts_pkg::OP_SET, 1023, '0);
		issue(fsts_pkg::OP_SET, 0, '1);
		issue(OP_NONE, 1023, '1);
		issue(fsts_pkg::OP_SET, 1, 32'hAAAA_AAAA);
		issue(fsts_pkg::OP_FILL, 1023, '1);
		issue(fsts_pkg::OP_SET, 5, '0);
		issue(fsts_pkg::OP_SET, 5, 32'd1);
		issue(fsts_pkg::OP_LOAD, 7, 32'd2);
		issue(fsts_pkg::OP_SET, 7, 32'd3);
		issue(fsts_pkg::OP_FILL, 0, '0);
		// small count: out-of-range indices
		set_entry_count(11'd3);
		issue(fsts_pkg::OP_LOAD, 3, 32'd5);
		issue(fsts_pkg::OP_SET, 1023, 32'd5);
		issue(fsts_pkg::OP_LOAD, 2, 32'd9);
		issue(fsts_pkg::OP_SET, 2, 32'd4);
		issue(fsts_pkg::OP_FILL, 0, 32'd7);
		issue(fsts_pkg::OP_SET, 0, 32'd1);
		// zero count: everything out of range, fill sums to zero
		set_entry_count(11'd0);
		issue(fsts_pkg::OP_LOAD, 0, 32'd1);
		issue(fsts_pkg::OP_SET, 0, 32'd1);
		issue(fsts_pkg::OP_FILL, 0, 32'd123);
		// count past the table depth saturates
		set_entry_count(COUNT_MAX);
		issue(fsts_pkg::OP_FILL, 0, 32'd1);
		issue(fsts_pkg::OP_SET, 1023, '1);
		issue(fsts_pkg::OP_LOAD, 512, '1);

		n_random = 0;
		phase    = 0;
		while (n_random < RANDOM_ITEMS) begin
			case (phase)
				0:       cnt = 11'd1;
				1:       cnt = CNT_W'(TABLE_DEPTH);
				2:       cnt = 11'd0;
				3:       cnt = COUNT_MAX;
				default: cnt = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(1, 64))
					: CNT_W'($urandom_range(65, 2047));
			endcase
			set_entry_count(cnt);
			idle_on  = ($urandom_range(0, 3) != 0);
			fill_pct = ($urandom_range(0, 3) == 0) ? 60 : 15;
			// small tables start with every active entry loaded once
			if (sb.active() <= 64) begin
				for (i = 0; i < sb.active(); i++) begin
					issue(fsts_pkg::OP_LOAD, i, pick_value());
					n_random++;
				end
			end
			len = $urandom_range(30, 80);
			repeat (len) begin
				r = pick_request(fill_pct);
				send(r);
				if (r.operation != OP_NONE)
					n_random++;
				quiet = (n_random + 150 >= RANDOM_ITEMS);
			end
			phase++;
		end

		drain();
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
